// ===== hw/rtl/q15dtk_pkg.sv =====
// ----------------------------------------------------------------------------
// q15dtk_pkg: shared types and constants of the Q15 top-k search block
// Field widths, the item format that travels through the command queue, and
// the helper that sizes the ranking list.
// ----------------------------------------------------------------------------
package q15dtk_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int VECTOR_LEN_DEF = 4;
   localparam int FRAC_BITS_DEF  = 15;

   localparam int IN_ELEMS    = 4;
   localparam int ELEM_W      = 16;
   localparam int IDX_IN_W    = 4;
   localparam int K_W         = 5;
   localparam int RANK_W      = 4;
   localparam int MAX_RESULTS = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int SIM_W       = PROD_W + $clog2(IN_ELEMS);
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // One classified command as the front end hands it to the back end.
   typedef struct packed {
      logic                               is_query;
      logic [K_W-1:0]                     want;
      logic [IDX_IN_W-1:0]                idx;
      logic [IN_ELEMS-1:0][ELEM_W-1:0]    elems;
   } item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   // Length of the ranking list: never more picks than entries or results.
   function automatic int list_len(input int entries);
      return (entries < MAX_RESULTS) ? entries : MAX_RESULTS;
   endfunction

endpackage

// ===== hw/rtl/q15_dot_product_top_k_search.sv =====
// ----------------------------------------------------------------------------
// A load reaches the store at the edge that takes it off the queue; a query
// reads every store entry through the single read port of the corpus store,
// then gives one beat per rank, one beat per cycle while rsp_stall is low.
// The back end finishes each command before it takes the next one. Synchronous
// reset empties the queue and marks every store entry as zero.
// ----------------------------------------------------------------------------
module q15_dot_product_top_k_search #(
   parameter int ENTRIES    = q15dtk_pkg::ENTRIES_DEF,
   parameter int VECTOR_LEN = q15dtk_pkg::VECTOR_LEN_DEF,
   parameter int FRAC_BITS  = q15dtk_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [q15dtk_pkg::IDX_IN_W-1:0]      req_entry_index,
   input  logic signed [q15dtk_pkg::ELEM_W-1:0] req_elem0,
   input  logic signed [q15dtk_pkg::ELEM_W-1:0] req_elem1,
   input  logic signed [q15dtk_pkg::ELEM_W-1:0] req_elem2,
   input  logic signed [q15dtk_pkg::ELEM_W-1:0] req_elem3,
   input  logic [q15dtk_pkg::K_W-1:0]           req_k,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [q15dtk_pkg::IDX_IN_W-1:0]      rsp_neighbor_index,
   output logic [q15dtk_pkg::RANK_W-1:0]        rsp_rank,
   output logic                                 rsp_found,
   output logic                                 rsp_last
);

   // The front end accepts a request beat whenever the command queue has
   // room, so new commands keep arriving while the back end is busy with a
   // long query or while a result beat waits on rsp_stall. Loads whose
   // entry_index lies beyond the store are accepted and dropped right here.
   // The pick count of a query is capped at the list length up front.

   q15dtk_pkg::q_status_type q_status;
   q15dtk_pkg::item_type     push_item;
   q15dtk_pkg::item_type     head;
   logic                     push;
   logic                     pop;

   q15dtk_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_entry_index (req_entry_index),
      .req_elem0       (req_elem0),
      .req_elem1       (req_elem1),
      .req_elem2       (req_elem2),
      .req_elem3       (req_elem3),
      .req_k           (req_k),
      .q_status        (q_status),
      .push            (push),
      .push_item       (push_item)
   );

   // Commands are kept in order, so a load queued behind a query only
   // changes the store after that query has read every entry.
   q15dtk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_status  (q_status),
      .head      (head)
   );

   // The back end reads one store entry per cycle, forms the four Q15
   // products in one stage, truncates and sums them in the next, and sorts
   // the similarity into a ranking list as it arrives. Once the list is
   // complete it sends one beat per rank through a registered output that
   // holds its payload while rsp_stall is high. A query asking for no
   // neighbors gives a single beat with found low and last high.
   q15dtk_back #(
      .ENTRIES    (ENTRIES),
      .VECTOR_LEN (VECTOR_LEN),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .head               (head),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_rank           (rsp_rank),
      .rsp_found          (rsp_found),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== hw/rtl/q15dtk_front.sv =====
// ----------------------------------------------------------------------------
// q15dtk_front: command front end
// Takes request beats, drops loads aimed past the store, caps the pick count
// and pushes the classified command into the queue.
// ----------------------------------------------------------------------------
module q15dtk_front #(
   parameter int ENTRIES = q15dtk_pkg::ENTRIES_DEF
) (
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [q15dtk_pkg::IDX_IN_W-1:0]     req_entry_index,
   input  logic signed [q15dtk_pkg::ELEM_W-1:0] req_elem0,
   input  logic signed [q15dtk_pkg::ELEM_W-1:0] req_elem1,
   input  logic signed [q15dtk_pkg::ELEM_W-1:0] req_elem2,
   input  logic signed [q15dtk_pkg::ELEM_W-1:0] req_elem3,
   input  logic [q15dtk_pkg::K_W-1:0]          req_k,
   input  q15dtk_pkg::q_status_type            q_status,
   output logic                                push,
   output q15dtk_pkg::item_type                push_item
);

   localparam int LIST_N = q15dtk_pkg::list_len(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = CNT_W + q15dtk_pkg::IDX_IN_W;

   logic                          is_query;
   logic                          in_range;
   logic [q15dtk_pkg::K_W-1:0]    want;

   assign is_query = (req_operation == q15dtk_pkg::OP_QUERY);
   assign in_range = CMP_W'(req_entry_index) < CMP_W'(ENTRIES);
   assign want     = (req_k > q15dtk_pkg::K_W'(LIST_N)) ? q15dtk_pkg::K_W'(LIST_N) : req_k;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full && (is_query || in_range);

   always_comb begin
      push_item          = '0;
      push_item.is_query = is_query;
      push_item.want     = want;
      push_item.idx      = req_entry_index;
      push_item.elems[0] = req_elem0;
      push_item.elems[1] = req_elem1;
      push_item.elems[2] = req_elem2;
      push_item.elems[3] = req_elem3;
   end

endmodule

// ===== hw/rtl/q15dtk_queue.sv =====
// ----------------------------------------------------------------------------
// q15dtk_queue: command queue
// A short FIFO of classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
module q15dtk_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  q15dtk_pkg::item_type      push_item,
   input  logic                      pop,
   output q15dtk_pkg::q_status_type  q_status,
   output q15dtk_pkg::item_type      head
);

   localparam int DEPTH = q15dtk_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   q15dtk_pkg::item_type slots_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign q_status.full      = (cnt_ff == CNT_W'(DEPTH));
   assign q_status.not_empty = (cnt_ff != '0);
   assign head               = slots_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/q15dtk_back.sv =====
// ----------------------------------------------------------------------------
// q15dtk_back: execution back end
// Owns the corpus store. Loads write one entry; queries stream every entry
// through a multiply and sum pipeline into an insertion-sorted ranking list,
// then hand the ranked indices out through the result register.
// ----------------------------------------------------------------------------
module q15dtk_back #(
   parameter int ENTRIES    = q15dtk_pkg::ENTRIES_DEF,
   parameter int VECTOR_LEN = q15dtk_pkg::VECTOR_LEN_DEF,
   parameter int FRAC_BITS  = q15dtk_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  q15dtk_pkg::q_status_type         q_status,
   input  q15dtk_pkg::item_type             head,
   output logic                             pop,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [q15dtk_pkg::IDX_IN_W-1:0]  rsp_neighbor_index,
   output logic [q15dtk_pkg::RANK_W-1:0]    rsp_rank,
   output logic                             rsp_found,
   output logic                             rsp_last
);

   localparam int IN_ELEMS = q15dtk_pkg::IN_ELEMS;
   localparam int ELEM_W   = q15dtk_pkg::ELEM_W;
   localparam int K_W      = q15dtk_pkg::K_W;
   localparam int PROD_W   = q15dtk_pkg::PROD_W;
   localparam int SIM_W    = q15dtk_pkg::SIM_W;
   localparam int USED     = (VECTOR_LEN < IN_ELEMS) ? VECTOR_LEN : IN_ELEMS;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int LIST_N   = q15dtk_pkg::list_len(ENTRIES);
   localparam int LIST_W   = $clog2(LIST_N);
   localparam int BIAS_W   = PROD_W + 1;
   localparam logic [BIAS_W-1:0] BIAS = BIAS_W'((64'd1 << FRAC_BITS) - 64'd1);

   typedef logic [USED-1:0][ELEM_W-1:0] vec_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   vec_type              qvec_ff, qvec_in;
   logic [K_W-1:0]       want_ff, want_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic [K_W-1:0]       rank_ff, rank_in;

   // Corpus store with one valid bit per entry; an entry never written reads
   // as a zero vector.
   vec_type              corpus_mem_ff [ENTRIES];
   logic                 vbits_ff [ENTRIES];
   logic                 mem_we;
   logic [IDX_W-1:0]     wr_addr;
   vec_type              wr_vec;
   logic [IDX_W-1:0]     rd_addr;

   // Similarity pipeline.
   logic                 s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic                 ent_vld_ff;
   vec_type              mem_q_ff;
   vec_type              ent_vec;

   logic                      s2_vld_ff;
   logic [IDX_W-1:0]          s2_idx_ff;
   logic signed [PROD_W-1:0]  prod_ff [USED];
   logic signed [PROD_W-1:0]  prod_in [USED];

   logic                      s3_vld_ff;
   logic [IDX_W-1:0]          s3_idx_ff;
   logic signed [SIM_W-1:0]   sim_ff, sim_in;
   logic signed [BIAS_W-1:0]  lane_biased [USED];
   logic signed [BIAS_W-1:0]  lane_tr [USED];

   // Ranking list, best first.
   logic                      list_used_ff [LIST_N];
   logic                      list_used_in [LIST_N];
   logic signed [SIM_W-1:0]   list_sim_ff [LIST_N];
   logic signed [SIM_W-1:0]   list_sim_in [LIST_N];
   logic [IDX_W-1:0]          list_idx_ff [LIST_N];
   logic [IDX_W-1:0]          list_idx_in [LIST_N];
   logic                      gt [LIST_N];

   // Result register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [q15dtk_pkg::IDX_IN_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [q15dtk_pkg::RANK_W-1:0]        rsp_rank_ff, rsp_rank_in;
   logic                                 rsp_found_ff, rsp_found_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic                                 out_free;
   logic                                 emit_found;
   logic                                 emit_last;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   assign s1_vld_in = (state_ff == ST_SCAN) && (rd_cnt_ff < CNT_W'(ENTRIES));
   assign rd_addr   = s1_vld_in ? rd_cnt_ff[IDX_W-1:0] : '0;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_found = (want_ff != '0);
   assign emit_last  = !emit_found || (K_W'(rank_ff + 1'b1) == want_ff);
   assign wr_addr   = IDX_W'(head.idx);

   always_comb begin
      for (int l = 0; l < USED; l++) begin
         wr_vec[l] = head.elems[l];
      end
   end

   always_comb begin
      state_in     = state_ff;
      qvec_in      = qvec_ff;
      want_in      = want_ff;
      rd_cnt_in    = rd_cnt_ff;
      rank_in      = rank_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in   = rsp_idx_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               pop = 1'b1;
               if (head.is_query) begin
                  qvec_in   = wr_vec;
                  want_in   = head.want;
                  rd_cnt_in = '0;
                  rank_in   = '0;
                  state_in  = (head.want == '0) ? ST_EMIT : ST_SCAN;
               end else begin
                  mem_we = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (s1_vld_in) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end else if (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = emit_found ?
                              q15dtk_pkg::IDX_IN_W'(list_idx_ff[rank_ff[LIST_W-1:0]]) : '0;
               rsp_rank_in  = rank_ff[q15dtk_pkg::RANK_W-1:0];
               rsp_found_in = emit_found;
               rsp_last_in  = emit_last;
               rank_in      = rank_ff + 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         rank_ff      <= '0;
         want_ff      <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         rank_ff      <= rank_in;
         want_ff      <= want_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Corpus store
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         corpus_mem_ff[wr_addr] <= wr_vec;
      end
      mem_q_ff <= corpus_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < ENTRIES; e++) begin
            vbits_ff[e] <= 1'b0;
         end
      end else if (mem_we) begin
         vbits_ff[wr_addr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Similarity pipeline: products, then truncate toward zero and sum.
   // ---------------------------------------------------------------------
   assign ent_vec = ent_vld_ff ? mem_q_ff : '0;

   always_comb begin
      for (int l = 0; l < USED; l++) begin
         prod_in[l] = $signed(qvec_ff[l]) * $signed(ent_vec[l]);
      end
   end

   // Adding 2^F-1 to a negative product before the arithmetic shift makes
   // the shift round toward zero.
   always_comb begin
      sim_in = '0;
      for (int l = 0; l < USED; l++) begin
         lane_biased[l] = {prod_ff[l][PROD_W-1], prod_ff[l]} +
                          (prod_ff[l][PROD_W-1] ? BIAS : '0);
         lane_tr[l]     = lane_biased[l] >>> FRAC_BITS;
         sim_in         = sim_in + SIM_W'(lane_tr[l]);
      end
   end

   always_ff @(posedge clock) begin
      qvec_ff    <= qvec_in;
      ent_vld_ff <= vbits_ff[rd_addr];
      s1_idx_ff  <= rd_addr;
      s2_idx_ff  <= s1_idx_ff;
      s3_idx_ff  <= s2_idx_ff;
      sim_ff     <= sim_in;
      for (int l = 0; l < USED; l++) begin
         prod_ff[l] <= prod_in[l];
      end
   end

   // ---------------------------------------------------------------------
   // Ranking list. A new entry lands before the first slot that is empty or
   // holds a smaller similarity; equal values stay ahead, so ties keep the
   // lower index first. The tail drops off when the list is full.
   // ---------------------------------------------------------------------
   always_comb begin
      for (int j = 0; j < LIST_N; j++) begin
         gt[j] = !list_used_ff[j] || (sim_ff > list_sim_ff[j]);
      end

      list_used_in[0] = list_used_ff[0];
      list_sim_in[0]  = list_sim_ff[0];
      list_idx_in[0]  = list_idx_ff[0];
      if (s3_vld_ff && gt[0]) begin
         list_used_in[0] = 1'b1;
         list_sim_in[0]  = sim_ff;
         list_idx_in[0]  = s3_idx_ff;
      end

      for (int j = 1; j < LIST_N; j++) begin
         list_used_in[j] = list_used_ff[j];
         list_sim_in[j]  = list_sim_ff[j];
         list_idx_in[j]  = list_idx_ff[j];
         if (s3_vld_ff && gt[j]) begin
            if (!gt[j-1]) begin
               list_used_in[j] = 1'b1;
               list_sim_in[j]  = sim_ff;
               list_idx_in[j]  = s3_idx_ff;
            end else begin
               list_used_in[j] = list_used_ff[j-1];
               list_sim_in[j]  = list_sim_ff[j-1];
               list_idx_in[j]  = list_idx_ff[j-1];
            end
         end
      end

      if (pop && head.is_query) begin
         for (int j = 0; j < LIST_N; j++) begin
            list_used_in[j] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LIST_N; j++) begin
            list_used_ff[j] <= 1'b0;
         end
      end else begin
         for (int j = 0; j < LIST_N; j++) begin
            list_used_ff[j] <= list_used_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < LIST_N; j++) begin
         list_sim_ff[j] <= list_sim_in[j];
         list_idx_ff[j] <= list_idx_in[j];
      end
      rsp_idx_ff   <= rsp_idx_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbor_index = rsp_idx_ff;
   assign rsp_rank           = rsp_rank_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ===== hw/rtl/q15dtk_checker.sv =====
// ----------------------------------------------------------------------------
// q15dtk_checker: result port checks
// Watches the result channel of the top level and checks the ranking order
// and the shape of empty answers.
// ----------------------------------------------------------------------------
module q15dtk_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [q15dtk_pkg::IDX_IN_W-1:0]     rsp_neighbor_index,
   input logic [q15dtk_pkg::RANK_W-1:0]       rsp_rank,
   input logic                                rsp_found,
   input logic                                rsp_last
);

   logic [q15dtk_pkg::RANK_W-1:0] exp_rank_ff, exp_rank_in;
   logic                          rsp_beat;

   assign rsp_beat = rsp_valid && !rsp_stall;

   always_comb begin
      exp_rank_in = exp_rank_ff;
      if (rsp_beat) begin
         exp_rank_in = rsp_last ? '0 : rsp_rank + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_rank_ff <= '0;
      end else begin
         exp_rank_ff <= exp_rank_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_neighbor_index) &&
      $stable(rsp_rank) && $stable(rsp_found) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rank == exp_rank_ff)
      else $error("rank does not follow the previous beat of the query");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_rank == '0 && rsp_neighbor_index == '0)
      else $error("empty answer is not a single final beat");

endmodule

bind q15_dot_product_top_k_search q15dtk_checker u_q15dtk_checker (.*);
